@@ hw/rtl/ihrc_pkg.sv @@
// Shared types, constants and the hex digit decoder of the HEX record checker.
// Used by every module of the block; depends on nothing.
package ihrc_pkg;

	localparam int BUFFER_BYTES_DEF = 32;
	localparam int QUEUE_DEPTH      = 2;
	localparam int LEN_W            = 10;

	localparam logic [LEN_W-1:0] MIN_LINE = LEN_W'(11);

	// Character positions (counted from the start mark) whose byte completes
	// one of the fixed header fields or the extended address.
	localparam int POS_COUNT   = 2;
	localparam int POS_ADDR_HI = 4;
	localparam int POS_ADDR_LO = 6;
	localparam int POS_KIND    = 8;
	localparam int POS_EXT_HI  = 10;
	localparam int POS_EXT_LO  = 12;

	// Store index of the first data byte.
	localparam int DATA_FIRST = 5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BUSY     = 3'd1;
	localparam logic [2:0] ST_LENGTH   = 3'd2;
	localparam logic [2:0] ST_CHECKSUM = 3'd3;
	localparam logic [2:0] ST_KIND     = 3'd4;

	localparam logic [7:0] KIND_DATA = 8'h00;
	localparam logic [7:0] KIND_EOF  = 8'h01;
	localparam logic [7:0] KIND_EXT  = 8'h04;

	// One finished line, handed from the decoder to the result sequencer.
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  kind;
		logic [30:0] word_addr;
		logic [7:0]  count;
		logic [15:0] err_total;
		logic        has_data;
	} cmd_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok    = 1'b1;
		r.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.value = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.value = 4'(c - 8'h57);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/ihrc_front.sv @@
// Character decoder: turns the characters of a line into bytes, keeps the
// running sum and header fields, and classifies the line at its end.
// Depends on ihrc_pkg.
module ihrc_front #(
	parameter int BUFFER_BYTES = ihrc_pkg::BUFFER_BYTES_DEF,
	parameter int AW = $clog2(BUFFER_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          character,
	input  logic                end_of_line,
	input  logic                programmer_busy,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [7:0]          wr_data,
	output logic                push,
	output ihrc_pkg::cmd_t      cmd,
	input  logic                queue_full,
	input  logic                data_done
);
	localparam int CW = $clog2(2 * BUFFER_BYTES + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(2 * BUFFER_BYTES);

	logic [CW-1:0]  cnt_q;
	logic [3:0]     hi_q;
	logic [7:0]     sum_q;
	logic           fault_q;
	logic [7:0]     cb_q, addr_hi_q, addr_lo_q, kind_q, ext_hi_q, ext_lo_q;
	logic [15:0]    ext_q;
	logic [15:0]    err_q;
	logic           lock_q;

	ihrc_pkg::hex_t hx;
	logic           accept, active, byte_done;
	logic [7:0]     byte_val;
	logic [7:0]     sum_n;
	logic           fault_n;
	logic [ihrc_pkg::LEN_W-1:0] len, need_len;
	logic [2:0]     st;
	logic           decoded;
	logic [15:0]    addr;
	logic [15:0]    err_n;

	assign in_stall = lock_q | queue_full;
	assign accept   = in_valid & ~in_stall;
	assign hx       = ihrc_pkg::hex_decode(character);
	assign active   = (cnt_q != '0) & ~fault_q;
	assign byte_val = {hi_q, hx.value};
	assign byte_done = active & (cnt_q < CNT_FULL) & hx.ok & ~cnt_q[0];

	assign wr_en   = accept & byte_done;
	assign wr_addr = cnt_q[AW:1];
	assign wr_data = byte_val;

	assign sum_n   = byte_done ? sum_q + byte_val : sum_q;
	assign fault_n = fault_q | (active & ((cnt_q >= CNT_FULL) | ~hx.ok));

	assign len      = ihrc_pkg::LEN_W'(cnt_q) + ihrc_pkg::LEN_W'(1);
	assign need_len = {1'b0, cb_q, 1'b0} + ihrc_pkg::MIN_LINE;
	assign addr     = {addr_hi_q, addr_lo_q};

	// Line verdict, in the order the checks take precedence.
	always_comb begin
		decoded = 1'b0;
		if (programmer_busy) begin
			st = ihrc_pkg::ST_BUSY;
		end else if (len < ihrc_pkg::MIN_LINE || !len[0] || fault_n) begin
			st = ihrc_pkg::ST_LENGTH;
		end else begin
			decoded = 1'b1;
			if (sum_n != 8'd0) begin
				st = ihrc_pkg::ST_CHECKSUM;
			end else if (len != need_len) begin
				st = ihrc_pkg::ST_LENGTH;
			end else if (kind_q == ihrc_pkg::KIND_EOF) begin
				st = ihrc_pkg::ST_OK;
			end else if (kind_q == ihrc_pkg::KIND_EXT) begin
				st = (cb_q != 8'd2 || addr != 16'd0) ? ihrc_pkg::ST_KIND : ihrc_pkg::ST_OK;
			end else if (kind_q == ihrc_pkg::KIND_DATA) begin
				st = ihrc_pkg::ST_OK;
			end else begin
				st = ihrc_pkg::ST_KIND;
			end
		end
	end

	assign err_n = (st != ihrc_pkg::ST_OK) ? err_q + 16'd1 : err_q;

	assign push = accept & end_of_line;
	always_comb begin
		cmd.status    = st;
		cmd.kind      = decoded ? kind_q : 8'd0;
		cmd.count     = cb_q;
		cmd.err_total = err_n;
		cmd.has_data  = decoded && st == ihrc_pkg::ST_OK &&
			kind_q == ihrc_pkg::KIND_DATA && cb_q != 8'd0;
		cmd.word_addr = cmd.has_data ? {ext_q, addr[15:1]} : 31'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			hi_q    <= '0;
			sum_q   <= '0;
			fault_q <= 1'b0;
			ext_q   <= '0;
			err_q   <= '0;
			lock_q  <= 1'b0;
		end else begin
			if (data_done) begin
				lock_q <= 1'b0;
			end
			if (accept) begin
				if (end_of_line) begin
					cnt_q   <= '0;
					hi_q    <= '0;
					sum_q   <= '0;
					fault_q <= 1'b0;
					err_q   <= err_n;
					if (cmd.has_data) begin
						lock_q <= 1'b1;
					end
					if (decoded && st == ihrc_pkg::ST_OK) begin
						if (kind_q == ihrc_pkg::KIND_EOF) begin
							ext_q <= '0;
						end else if (kind_q == ihrc_pkg::KIND_EXT) begin
							ext_q <= {ext_hi_q, ext_lo_q};
						end
					end
				end else begin
					if (cnt_q < CNT_FULL) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (active && cnt_q < CNT_FULL && hx.ok && cnt_q[0]) begin
						hi_q <= hx.value;
					end
					sum_q   <= sum_n;
					fault_q <= fault_n;
				end
			end
		end
	end

	// Header fields are picked up as their bytes complete.
	always_ff @(posedge clk) begin
		if (accept && byte_done) begin
			if (cnt_q == CW'(ihrc_pkg::POS_COUNT)) cb_q <= byte_val;
			if (cnt_q == CW'(ihrc_pkg::POS_ADDR_HI)) addr_hi_q <= byte_val;
			if (cnt_q == CW'(ihrc_pkg::POS_ADDR_LO)) addr_lo_q <= byte_val;
			if (cnt_q == CW'(ihrc_pkg::POS_KIND)) kind_q <= byte_val;
			if (cnt_q == CW'(ihrc_pkg::POS_EXT_HI)) ext_hi_q <= byte_val;
			if (cnt_q == CW'(ihrc_pkg::POS_EXT_LO)) ext_lo_q <= byte_val;
		end
	end

endmodule

@@ hw/rtl/ihrc_fifo.sv @@
// Short command queue between the decoder and the result sequencer.
// Depends on ihrc_pkg.
module ihrc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ihrc_pkg::cmd_t din,
	input  logic           pop,
	output ihrc_pkg::cmd_t dout,
	output logic           empty,
	output logic           full
);
	localparam int PW = $clog2(ihrc_pkg::QUEUE_DEPTH);
	localparam int NW = $clog2(ihrc_pkg::QUEUE_DEPTH + 1);

	ihrc_pkg::cmd_t      slot_q [ihrc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]       wp_q, rp_q;
	logic [NW-1:0]       num_q;

	assign empty = (num_q == '0);
	assign full  = (num_q == NW'(ihrc_pkg::QUEUE_DEPTH));
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			num_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(ihrc_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(ihrc_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				num_q <= num_q + NW'(1);
			end else if (pop && !push) begin
				num_q <= num_q - NW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/ihrc_back.sv @@
// Result sequencer: holds the record byte store, takes line commands from
// the queue and emits one result word per data byte or one status word.
// Depends on ihrc_pkg.
module ihrc_back #(
	parameter int BUFFER_BYTES = ihrc_pkg::BUFFER_BYTES_DEF,
	parameter int AW = $clog2(BUFFER_BYTES)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  logic [7:0]     wr_data,
	input  logic           q_empty,
	input  ihrc_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           data_done,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     status,
	output logic [7:0]     record_kind,
	output logic [30:0]    word_address,
	output logic [4:0]     byte_index,
	output logic [7:0]     data_byte,
	output logic           data_valid,
	output logic [15:0]    error_total,
	output logic           last_of_run
);
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_READ   = 4'b0010,
		S_LOAD   = 4'b0100,
		S_SINGLE = 4'b1000
	} state_t;

	state_t         state_q;
	ihrc_pkg::cmd_t cmd_q;
	logic [7:0]     mem_q [BUFFER_BYTES];
	logic [7:0]     rd_q;
	logic [AW-1:0]  ptr_q;
	logic [7:0]     idx_q;
	logic           free, last, rd_en;
	logic [AW-1:0]  ptr_next;

	assign free     = ~out_valid | ~out_stall;
	assign last     = (idx_q == cmd_q.count - 8'd1);
	assign ptr_next = (ptr_q == AW'(BUFFER_BYTES - 1)) ? '0 : ptr_q + AW'(1);
	assign q_pop    = (state_q == S_IDLE) & ~q_empty;
	assign rd_en    = (state_q == S_READ) | ((state_q == S_LOAD) & free & ~last);
	assign data_done = (state_q == S_LOAD) & free & last;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[(state_q == S_READ) ? ptr_q : ptr_next];
		end
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ptr_q     <= '0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						ptr_q   <= AW'(ihrc_pkg::DATA_FIRST % BUFFER_BYTES);
						idx_q   <= '0;
						state_q <= q_cmd.has_data ? S_READ : S_SINGLE;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (free) begin
						out_valid <= 1'b1;
						if (last) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_next;
							idx_q <= idx_q + 8'd1;
						end
					end
				end
				S_SINGLE: begin
					if (free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; only loaded when a word goes into the output register.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && free) begin
			status       <= ihrc_pkg::ST_OK;
			record_kind  <= cmd_q.kind;
			word_address <= cmd_q.word_addr;
			byte_index   <= idx_q[4:0];
			data_byte    <= rd_q;
			data_valid   <= 1'b1;
			error_total  <= cmd_q.err_total;
			last_of_run  <= last;
		end else if (state_q == S_SINGLE && free) begin
			status       <= cmd_q.status;
			record_kind  <= cmd_q.kind;
			word_address <= '0;
			byte_index   <= '0;
			data_byte    <= '0;
			data_valid   <= 1'b0;
			error_total  <= cmd_q.err_total;
			last_of_run  <= 1'b1;
		end
	end

endmodule

@@ hw/rtl/intel_hex_record_checker_top.sv @@
// Top level of the HEX record checker: decoder, command queue and result
// sequencer. Depends on ihrc_pkg, ihrc_front, ihrc_fifo and ihrc_back.
//
// Usage. The input channel carries one character word per accepted cycle
// (in_valid high, in_stall low), with end_of_line on the last character of
// a record line and programmer_busy sampled on that same word. The first
// character of a line is skipped as the start mark.
// The decoder takes one character per cycle while in_stall is low. At the
// end of a line it queues one command; the sequencer then gives either a
// single status word or one word per data byte of an accepted data record,
// on the output channel (out_valid and out_stall). The last word of a line
// has last_of_run set. A status word is loaded from the queued command; for
// data words the byte store is read first, and they then follow at one per
// cycle while out_stall is low. The output register holds a word until it
// is taken, so a stalled receiver backs up into the two-entry queue.
// Because the byte store is shared, in_stall stays high from the end of a
// data record until its last data byte has gone into the output register;
// it is also high while the queue is full. A status-only line blocks the
// next line only by filling the queue. Reset clears the line state, the
// extended address and the error counter; the byte store needs no clearing.
module intel_hex_record_checker_top #(
	parameter int BUFFER_BYTES = ihrc_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        end_of_line,
	input  logic        programmer_busy,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  record_kind,
	output logic [30:0] word_address,
	output logic [4:0]  byte_index,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic [15:0] error_total,
	output logic        last_of_run
);
	localparam int AW = $clog2(BUFFER_BYTES);

	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;
	logic           push, pop, q_empty, q_full, data_done;
	ihrc_pkg::cmd_t cmd_in, cmd_out;

	ihrc_front #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.character(character),
		.end_of_line(end_of_line),
		.programmer_busy(programmer_busy),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.push(push),
		.cmd(cmd_in),
		.queue_full(q_full),
		.data_done(data_done)
	);

	// Commands wait here so the decoder can start the next line while a
	// status word is still held by a stalled receiver.
	ihrc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(cmd_in),
		.pop(pop),
		.dout(cmd_out),
		.empty(q_empty),
		.full(q_full)
	);

	ihrc_back #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.q_empty(q_empty),
		.q_cmd(cmd_out),
		.q_pop(pop),
		.data_done(data_done),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.record_kind(record_kind),
		.word_address(word_address),
		.byte_index(byte_index),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.error_total(error_total),
		.last_of_run(last_of_run)
	);

endmodule

@@ sim/record_result_checker.sv @@
// Result checker for the HEX record checker: predicts every result word from the accepted
// character words and compares it with what the block hands out. Depends on ihrc_pkg.
module record_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  character,
	input  logic        end_of_line,
	input  logic        programmer_busy,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [7:0]  record_kind,
	input  logic [30:0] word_address,
	input  logic [4:0]  byte_index,
	input  logic [7:0]  data_byte,
	input  logic        data_valid,
	input  logic [15:0] error_total,
	input  logic        last_of_run,
	output int          fail_count,
	output int          pending,
	output int          line_count,
	output int          data_count,
	output int          status_count
);
	localparam int BUF           = ihrc_pkg::BUFFER_BYTES_DEF;
	localparam int SHORTEST_LINE = 11;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [2:0]  st;
		logic [7:0]  kind;
		logic [30:0] waddr;
		logic [4:0]  idx;
		logic [7:0]  dbyte;
		logic        dvalid;
		logic [15:0] errs;
		logic        last;
	} result_word_t;

	// Line state and the state that outlives a line.
	int          char_pos;
	logic [3:0]  first_digit;
	logic [7:0]  line_sum;
	logic        line_fault;
	logic [7:0]  bytes_seen [0:BUF-1];
	logic [15:0] ext_addr;
	logic [15:0] reject_count;

	result_word_t due_words [$];

	function automatic void hex_digit(input logic [7:0] c, output logic ok,
			output logic [3:0] v);
		ok = 1'b1;
		v  = 4'd0;
		if (c >= "0" && c <= "9") v = 4'(c - "0");
		else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
		else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
		else ok = 1'b0;
	endfunction

	task automatic decode_char(input logic [7:0] c, input logic eol, input logic busy);
		int           n, len, i;
		logic         ok;
		logic [3:0]   v;
		logic [7:0]   b, cnt, kind;
		logic [15:0]  addr;
		logic [2:0]   st;
		logic [31:0]  full_addr;
		result_word_t w;
		n = char_pos;
		if (n != 0 && !line_fault) begin
			if (n >= 2 * BUF) begin
				line_fault = 1'b1;
			end else begin
				hex_digit(c, ok, v);
				if (!ok) begin
					line_fault = 1'b1;
				end else if (n % 2 == 1) begin
					first_digit = v;
				end else begin
					b = {first_digit, v};
					line_sum = line_sum + b;
					bytes_seen[n / 2] = b;
				end
			end
		end
		if (char_pos < 2 * BUF) char_pos++;
		if (eol) begin
			len  = n + 1;
			kind = ihrc_pkg::KIND_DATA;
			cnt  = 8'd0;
			addr = 16'd0;
			if (busy) begin
				st = ihrc_pkg::ST_BUSY;
			end else if (len < SHORTEST_LINE || len % 2 == 0 || line_fault) begin
				st = ihrc_pkg::ST_LENGTH;
			end else begin
				cnt  = bytes_seen[1];
				addr = {bytes_seen[2], bytes_seen[3]};
				kind = bytes_seen[4];
				if (line_sum != 8'd0) begin
					st = ihrc_pkg::ST_CHECKSUM;
				end else if (len != 2 * cnt + SHORTEST_LINE) begin
					st = ihrc_pkg::ST_LENGTH;
				end else if (kind == ihrc_pkg::KIND_EOF) begin
					ext_addr = 16'd0;
					st = ihrc_pkg::ST_OK;
				end else if (kind == ihrc_pkg::KIND_EXT) begin
					if (cnt != 8'd2 || addr != 16'd0) begin
						st = ihrc_pkg::ST_KIND;
					end else begin
						ext_addr = {bytes_seen[5], bytes_seen[6]};
						st = ihrc_pkg::ST_OK;
					end
				end else if (kind == ihrc_pkg::KIND_DATA) begin
					st = ihrc_pkg::ST_OK;
				end else begin
					st = ihrc_pkg::ST_KIND;
				end
			end
			if (st != ihrc_pkg::ST_OK) reject_count = reject_count + 16'd1;
			char_pos    = 0;
			first_digit = 4'd0;
			line_sum    = 8'd0;
			line_fault  = 1'b0;
			line_count++;
			if (st == ihrc_pkg::ST_OK && kind == ihrc_pkg::KIND_DATA && cnt > 0) begin
				full_addr = {ext_addr, addr};
				for (i = 0; i < cnt; i++) begin
					w = '{st: ihrc_pkg::ST_OK, kind: kind, waddr: full_addr[31:1],
						idx: 5'(i), dbyte: bytes_seen[5 + i], dvalid: 1'b1,
						errs: reject_count, last: (i + 1 == cnt)};
					due_words.push_back(w);
					data_count++;
				end
			end else begin
				w = '{st: st, kind: kind, waddr: 31'd0, idx: 5'd0, dbyte: 8'd0,
					dvalid: 1'b0, errs: reject_count, last: 1'b1};
				due_words.push_back(w);
				status_count++;
			end
		end
	endtask

	task automatic compare_word();
		result_word_t got, want;
		string        bad;
		got = '{st: status, kind: record_kind, waddr: word_address, idx: byte_index,
			dbyte: data_byte, dvalid: data_valid, errs: error_total, last: last_of_run};
		if (due_words.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: result word with nothing expected: st=%0d kind=%h",
					$realtime, got.st, got.kind);
		end else begin
			want = due_words.pop_front();
			bad = "";
			if (got.st != want.st) bad = {bad, " status"};
			if (got.kind != want.kind) bad = {bad, " record_kind"};
			if (got.waddr != want.waddr) bad = {bad, " word_address"};
			if (got.idx != want.idx) bad = {bad, " byte_index"};
			if (got.dbyte != want.dbyte) bad = {bad, " data_byte"};
			if (got.dvalid != want.dvalid) bad = {bad, " data_valid"};
			if (got.errs != want.errs) bad = {bad, " error_total"};
			if (got.last != want.last) bad = {bad, " last_of_run"};
			if (bad != "") begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("%0t: mismatch in%s", $realtime, bad);
					$display("  got  st=%0d kind=%h wa=%h idx=%0d db=%h dv=%b err=%0d last=%b",
						got.st, got.kind, got.waddr, got.idx, got.dbyte, got.dvalid,
						got.errs, got.last);
					$display("  want st=%0d kind=%h wa=%h idx=%0d db=%h dv=%b err=%0d last=%b",
						want.st, want.kind, want.waddr, want.idx, want.dbyte, want.dvalid,
						want.errs, want.last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pos     = 0;
			first_digit  = 4'd0;
			line_sum     = 8'd0;
			line_fault   = 1'b0;
			ext_addr     = 16'd0;
			reject_count = 16'd0;
			due_words.delete();
			fail_count   = 0;
			pending      = 0;
			line_count   = 0;
			data_count   = 0;
			status_count = 0;
		end else begin
			if (out_valid && !out_stall) compare_word();
			if (in_valid && !in_stall) decode_char(character, end_of_line, programmer_busy);
			pending = due_words.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
// Top of the HEX record checker test: clock, reset, character stimulus, receiver stalls,
// watchdog and verdict. Depends on ihrc_pkg, intel_hex_record_checker_top and
// record_result_checker.
module testbench;
	// The watchdog limit. The longest legal stretch without any accepted word is a
	// sender gap plus the block latency plus a receiver stall.
	localparam int QUIET_LIMIT  = 2000;
	localparam int TOTAL_CHARS  = 470;
	localparam int MAX_GAP      = 13;
	localparam int MAX_DATA     = 26;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] START_MARK = 8'h3A;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  character = 8'h00;
	logic        end_of_line = 1'b0;
	logic        programmer_busy = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  record_kind;
	logic [30:0] word_address;
	logic [4:0]  byte_index;
	logic [7:0]  data_byte;
	logic        data_valid;
	logic [15:0] error_total;
	logic        last_of_run;

	int fail_count, pending, line_count, data_count, status_count;

	// When steady is set neither side idles, so some lines run back to back at full rate.
	bit         steady = 1'b0;
	// Forces lowercase hex letters for one directed line.
	bit         lower_only = 1'b0;
	int         chars_sent = 0;
	int         quiet_cycles = 0;
	logic [7:0] line_q [$];

	always #5 clk = ~clk;

	intel_hex_record_checker_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.character(character), .end_of_line(end_of_line),
		.programmer_busy(programmer_busy),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .record_kind(record_kind), .word_address(word_address),
		.byte_index(byte_index), .data_byte(data_byte), .data_valid(data_valid),
		.error_total(error_total), .last_of_run(last_of_run)
	);

	record_result_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.character(character), .end_of_line(end_of_line),
		.programmer_busy(programmer_busy),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .record_kind(record_kind), .word_address(word_address),
		.byte_index(byte_index), .data_byte(data_byte), .data_valid(data_valid),
		.error_total(error_total), .last_of_run(last_of_run),
		.fail_count(fail_count), .pending(pending), .line_count(line_count),
		.data_count(data_count), .status_count(status_count)
	);

	// Turns a nibble into an ASCII hex digit. Letters come in a random case unless
	// lowercase is forced.
	function automatic logic [7:0] digit_char(input logic [3:0] v);
		logic lower;
		lower = lower_only || ($urandom_range(0, 1) == 1);
		if (v < 10) return 8'h30 + 8'(v);
		return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		line_q.push_back(digit_char(b[7:4]));
		line_q.push_back(digit_char(b[3:0]));
	endfunction

	// Mostly short data records, now and then a long one up to the buffer limit.
	function automatic int pick_count();
		if ($urandom_range(0, 9) == 0) return $urandom_range(7, MAX_DATA);
		return $urandom_range(0, 6);
	endfunction

	// Builds one record line in line_q. The declared count and the number of data bytes
	// actually written may differ, and skew is added to the correct checksum. A fill
	// value of -1 means random data bytes.
	task automatic build_line(input logic [7:0] decl, input int ndata,
			input logic [15:0] addr, input logic [7:0] kind, input logic [7:0] skew,
			input int fill);
		logic [7:0] sum, b;
		int         i;
		line_q.delete();
		// The start mark is skipped by the block, so it is sometimes any byte at all.
		line_q.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : START_MARK);
		sum = decl + addr[15:8] + addr[7:0] + kind;
		push_byte(decl);
		push_byte(addr[15:8]);
		push_byte(addr[7:0]);
		push_byte(kind);
		for (i = 0; i < ndata; i++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			sum = sum + b;
			push_byte(b);
		end
		push_byte(8'h00 - sum + skew);
	endtask

	// A start mark followed by random hex digits, used for short and overlong lines.
	task automatic digit_line(input int ndigits);
		line_q.delete();
		line_q.push_back(START_MARK);
		repeat (ndigits) line_q.push_back(digit_char(4'($urandom)));
	endtask

	// Offers one character word. The sender idles first for a drawn number of cycles and
	// then holds the word until the block takes it. Called and left at a falling edge.
	task automatic put_char(input logic [7:0] c, input logic eol, input logic busy);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		character       <= c;
		end_of_line     <= eol;
		programmer_busy <= busy;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		chars_sent++;
	endtask

	// Sends line_q as one line. programmer_busy only matters on the final word, so on the
	// others it is random.
	task automatic send_line(input bit busy);
		int i;
		for (i = 0; i < line_q.size(); i++) begin
			if (i == line_q.size() - 1) put_char(line_q[i], 1'b1, busy);
			else put_char(line_q[i], 1'b0, 1'($urandom_range(0, 1)));
		end
	endtask

	// Stops sending until every predicted result word has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// One random line: mostly well-formed records with random content, the rest broken
	// records of every kind and plain noise.
	task automatic random_line();
		int             pick, c, n;
		logic [7:0]     k, bad;
		logic [15:0]    a;
		bit             busy;
		ihrc_pkg::hex_t h;
		busy = 1'b0;
		pick = $urandom_range(0, 99);
		c    = pick_count();
		a    = 16'($urandom);
		if (pick < 45) begin
			build_line(8'(c), c, a, ihrc_pkg::KIND_DATA, 8'd0, -1);
		end else if (pick < 52) begin
			c = $urandom_range(0, 2);
			build_line(8'(c), c, a, ihrc_pkg::KIND_EOF, 8'd0, -1);
		end else if (pick < 62) begin
			build_line(8'd2, 2, 16'd0, ihrc_pkg::KIND_EXT, 8'd0, -1);
		end else if (pick < 66) begin
			build_line(8'(c), c, a, ihrc_pkg::KIND_DATA, 8'($urandom_range(1, 255)), -1);
		end else if (pick < 70) begin
			// A non-hex character somewhere after the start mark.
			build_line(8'(c), c, a, ihrc_pkg::KIND_DATA, 8'd0, -1);
			n   = $urandom_range(1, line_q.size() - 1);
			bad = 8'($urandom);
			h   = ihrc_pkg::hex_decode(bad);
			if (h.ok) bad[7] = 1'b1;
			line_q[n] = bad;
		end else if (pick < 74) begin
			// The declared count disagrees with the data, while the checksum holds.
			if (c == 0) n = 1;
			else n = ($urandom_range(0, 1) == 1 && c < MAX_DATA) ? c + 1 : c - 1;
			build_line(8'(c), n, a, ihrc_pkg::KIND_DATA, 8'd0, -1);
		end else if (pick < 77) begin
			build_line(8'(c), c, a, ihrc_pkg::KIND_DATA, 8'd0, -1);
			line_q.push_back(digit_char(4'($urandom)));
		end else if (pick < 80) begin
			digit_line($urandom_range(0, 9));
		end else if (pick < 83) begin
			digit_line($urandom_range(2 * ihrc_pkg::BUFFER_BYTES_DEF,
				2 * ihrc_pkg::BUFFER_BYTES_DEF + 8));
		end else if (pick < 87) begin
			build_line(8'(c), c, a, ihrc_pkg::KIND_DATA, 8'd0, -1);
			busy = 1'b1;
		end else if (pick < 91) begin
			k = 8'($urandom_range(2, 255));
			if (k == ihrc_pkg::KIND_EXT) k = 8'h05;
			build_line(8'(c), c, a, k, 8'd0, -1);
		end else if (pick < 94) begin
			if ($urandom_range(0, 1) == 1) begin
				c = $urandom_range(0, 5);
				if (c == 2) c = 3;
				build_line(8'(c), c, 16'd0, ihrc_pkg::KIND_EXT, 8'd0, -1);
			end else begin
				build_line(8'd2, 2, 16'($urandom_range(1, 65535)), ihrc_pkg::KIND_EXT,
					8'd0, -1);
			end
		end else begin
			line_q.delete();
			repeat ($urandom_range(1, 70)) line_q.push_back(8'($urandom));
		end
		send_line(busy);
	endtask

	// The receiver draws a stall for every result word and then takes the next one.
	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Ends the run if no word moves on either channel for too long.
	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int left;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed lines. First the well-formed records: end of file, an extended
		// address at its top value, the longest data record at the top address, an
		// empty data record and a lowercase data record.
		build_line(8'd0, 0, 16'd0, ihrc_pkg::KIND_EOF, 8'd0, -1);
		send_line(1'b0);
		build_line(8'd2, 2, 16'd0, ihrc_pkg::KIND_EXT, 8'd0, 8'hFF);
		send_line(1'b0);
		build_line(8'(MAX_DATA), MAX_DATA, 16'hFFFF, ihrc_pkg::KIND_DATA, 8'd0, 8'hFF);
		send_line(1'b0);
		build_line(8'd0, 0, 16'h1234, ihrc_pkg::KIND_DATA, 8'd0, -1);
		send_line(1'b0);
		lower_only = 1'b1;
		build_line(8'd3, 3, 16'hABCD, ihrc_pkg::KIND_DATA, 8'd0, -1);
		send_line(1'b0);
		lower_only = 1'b0;
		// An end of file record clears the extended address for the next data record.
		build_line(8'd0, 0, 16'd0, ihrc_pkg::KIND_EOF, 8'd0, -1);
		send_line(1'b0);
		steady = 1'b1;
		build_line(8'd1, 1, 16'h0000, ihrc_pkg::KIND_DATA, 8'd0, 8'h00);
		send_line(1'b0);
		steady = 1'b0;
		// Then one line for each way a line is rejected.
		build_line(8'd2, 2, 16'h0100, ihrc_pkg::KIND_DATA, 8'd1, -1);
		send_line(1'b0);
		build_line(8'd1, 1, 16'h0010, ihrc_pkg::KIND_DATA, 8'd0, -1);
		send_line(1'b1);
		digit_line(2);
		send_line(1'b0);
		build_line(8'd1, 1, 16'h0020, ihrc_pkg::KIND_DATA, 8'd0, -1);
		line_q.push_back(digit_char(4'hA));
		send_line(1'b0);
		build_line(8'd1, 1, 16'h0030, ihrc_pkg::KIND_DATA, 8'd0, -1);
		line_q[5] = "G";
		send_line(1'b0);
		digit_line(2 * ihrc_pkg::BUFFER_BYTES_DEF + 5);
		send_line(1'b0);
		build_line(8'd4, 3, 16'h0040, ihrc_pkg::KIND_DATA, 8'd0, -1);
		send_line(1'b0);
		build_line(8'd1, 1, 16'h0000, ihrc_pkg::KIND_EXT, 8'd0, -1);
		send_line(1'b0);
		build_line(8'd2, 2, 16'h0002, ihrc_pkg::KIND_EXT, 8'd0, -1);
		send_line(1'b0);
		build_line(8'd0, 0, 16'h0000, 8'hFF, 8'd0, -1);
		send_line(1'b0);

		// The sender holds back here until the block has delivered everything.
		drain_results();

		// Random lines until the character budget of the run is used up.
		while (chars_sent < TOTAL_CHARS) begin
			steady = ($urandom_range(0, 5) == 0);
			random_line();
			if ($urandom_range(0, 19) == 0) drain_results();
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		left = pending;
		if (left != 0) $display("%0d expected result words never arrived", left);

		$display("summary: %0d characters in %0d lines, %0d data words and %0d status words",
			chars_sent, line_count, data_count, status_count);
		$display("summary: %0d mismatching or unexpected result words", fail_count);
		if (fail_count == 0 && left == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
